// ===== hdl/tcc16_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc16_pkg
// Shared types and constants for the 16-bit teaching core.
// ----------------------------------------------------------------------------
package tcc16_pkg;

  localparam int unsigned DefMemWords = 32768;
  localparam int unsigned DefNumRegs  = 8;

  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_RESTART = 2'd1;
  localparam logic [1:0] MODE_STEP    = 2'd2;
  localparam logic [1:0] MODE_READ    = 2'd3;

  localparam logic [1:0] CFG_START_PC = 2'd0;
  localparam logic [1:0] CFG_START_SP = 2'd1;
  localparam logic [1:0] CFG_START_BP = 2'd2;

  localparam logic [2:0] IDX_AC = 3'd4;
  localparam logic [2:0] IDX_SP = 3'd5;
  localparam logic [2:0] IDX_BP = 3'd6;
  localparam logic [2:0] IDX_PC = 3'd7;

  // memory address source
  localparam logic [2:0] ASEL_IN  = 3'd0;
  localparam logic [2:0] ASEL_PC  = 3'd1;
  localparam logic [2:0] ASEL_IMM = 3'd2;
  localparam logic [2:0] ASEL_RB  = 3'd3;
  localparam logic [2:0] ASEL_OFF = 3'd4;
  localparam logic [2:0] ASEL_SP  = 3'd5;

  // datapath actions
  localparam logic [3:0] ACT_NONE     = 4'd0;
  localparam logic [3:0] ACT_MEMWR_IN = 4'd1;
  localparam logic [3:0] ACT_RESTART  = 4'd2;
  localparam logic [3:0] ACT_RDREQ    = 4'd3;
  localparam logic [3:0] ACT_LATCH_IR = 4'd4;
  localparam logic [3:0] ACT_EXEC     = 4'd5;
  localparam logic [3:0] ACT_LOAD_RA  = 4'd6;
  localparam logic [3:0] ACT_STORE_RA = 4'd7;
  localparam logic [3:0] ACT_RET1     = 4'd8;
  localparam logic [3:0] ACT_RET2     = 4'd9;
  localparam logic [3:0] ACT_CALL1    = 4'd10;
  localparam logic [3:0] ACT_CALL2    = 4'd11;
  localparam logic [3:0] ACT_READOUT  = 4'd12;
  localparam logic [3:0] ACT_STEP     = 4'd13;

  typedef struct packed {
    logic [3:0] act;
    logic [2:0] asel;
  } tcc16_cmd_t;

  typedef struct packed {
    logic [1:0] group;
    logic [2:0] sub;
    logic       mod;
    logic [1:0] tt;
    logic [1:0] kind;
    logic       stopped;
  } tcc16_sts_t;

endpackage

// ===== hdl/tcc16_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc16_datapath
// Register file, word memory, ALU and result registers.
// ----------------------------------------------------------------------------
module tcc16_datapath #(
  parameter int unsigned MemWords = tcc16_pkg::DefMemWords
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tcc16_pkg::tcc16_cmd_t  cmd_i,
  output tcc16_pkg::tcc16_sts_t  sts_o,
  input  logic [15:0]            in_addr_i,
  input  logic [15:0]            in_wdata_i,
  input  logic [15:0]            start_pc_i,
  input  logic [15:0]            start_sp_i,
  input  logic [15:0]            start_bp_i,
  output logic [15:0]            read_word_o,
  output logic [15:0]            regs_o [8],
  output logic                   stopped_o
);
  import tcc16_pkg::*;

  localparam int unsigned AW = $clog2(MemWords);

  logic [15:0] mem_q [MemWords];
  logic [15:0] rf_q [8];
  logic [15:0] ir_q;
  logic [15:0] rdata_q;
  logic [15:0] rout_q;
  logic        stop_q;
  logic [15:0] addr;
  logic [15:0] wdata;
  logic        we;
  logic [2:0]  ra, rb;
  logic [15:0] imm8, offv, alu;

  assign ra   = ir_q[10:8];
  assign rb   = ir_q[7:5];
  assign imm8 = {8'd0, ir_q[7:0]};
  assign offv = rf_q[rb] + {{10{ir_q[4]}}, ir_q[4:0], 1'b0};

  always_comb begin
    case (cmd_i.asel)
      ASEL_IN:  addr = in_addr_i;
      ASEL_PC:  addr = rf_q[IDX_PC];
      ASEL_IMM: addr = imm8;
      ASEL_RB:  addr = rf_q[rb];
      ASEL_OFF: addr = offv;
      ASEL_SP:  addr = rf_q[IDX_SP];
      default:  addr = in_addr_i;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    wdata = rf_q[ra];
    case (cmd_i.act)
      ACT_MEMWR_IN: begin
        we    = 1'b1;
        wdata = in_wdata_i;
      end
      ACT_STORE_RA: we = 1'b1;
      ACT_CALL1: begin
        we    = 1'b1;
        wdata = rf_q[IDX_PC];
      end
      ACT_CALL2: begin
        we    = 1'b1;
        wdata = rf_q[IDX_BP];
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[addr[AW:1]] <= wdata;
    end
    rdata_q <= mem_q[addr[AW:1]];
  end

  always_comb begin
    case (ir_q[13:11])
      3'd0:    alu = 16'd0 - rf_q[ra];
      3'd1:    alu = rf_q[ra] + rf_q[rb];
      3'd2:    alu = rf_q[ra] + imm8;
      3'd3:    alu = rf_q[ra] - rf_q[rb];
      default: alu = rf_q[ra] - imm8;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) rf_q[i] <= '0;
      stop_q <= 1'b0;
      ir_q   <= '0;
      rout_q <= '0;
    end else begin
      case (cmd_i.act)
        ACT_RESTART: begin
          for (int i = 0; i < 5; i++) rf_q[i] <= '0;
          rf_q[IDX_PC] <= start_pc_i;
          rf_q[IDX_SP] <= start_sp_i;
          rf_q[IDX_BP] <= start_bp_i;
          stop_q       <= 1'b0;
          rout_q       <= '0;
        end
        ACT_RDREQ, ACT_MEMWR_IN, ACT_STEP: rout_q <= '0;
        ACT_LATCH_IR: begin
          ir_q         <= rdata_q;
          rf_q[IDX_PC] <= rf_q[IDX_PC] + 16'd2;
        end
        ACT_EXEC: begin
          case (ir_q[15:14])
            2'd0: if (ir_q[13:11] == 3'd0) stop_q <= 1'b1;
            2'd1: if (!ir_q[12] && ir_q[11:10] == 2'd0) rf_q[ra] <= imm8;
            2'd2: begin
              if (ir_q[13:11] == 3'd7) rf_q[ra] <= rf_q[rb];
              else if (ir_q[13:11] <= 3'd4) rf_q[IDX_AC] <= alu;
            end
            default: begin
              case (ir_q[13:12])
                2'd0: rf_q[IDX_PC] <= {4'd0, ir_q[11:0]};
                2'd1: if (rf_q[IDX_AC] == 16'd0) rf_q[IDX_PC] <= {4'd0, ir_q[11:0]};
                2'd2: if (rf_q[IDX_AC][15]) rf_q[IDX_PC] <= {4'd0, ir_q[11:0]};
                default: ;
              endcase
            end
          endcase
        end
        ACT_LOAD_RA: rf_q[ra] <= rdata_q;
        ACT_RET1: begin
          rf_q[IDX_BP] <= rdata_q;
          rf_q[IDX_SP] <= rf_q[IDX_SP] - 16'd2;
        end
        ACT_RET2: rf_q[IDX_PC] <= rdata_q;
        ACT_CALL1: begin
          rf_q[IDX_SP] <= rf_q[IDX_SP] + 16'd2;
          rf_q[IDX_PC] <= {4'd0, ir_q[11:0]};
        end
        ACT_CALL2: begin
          rf_q[IDX_BP] <= rf_q[IDX_SP];
          rf_q[IDX_SP] <= rf_q[IDX_SP] + 16'd2;
        end
        ACT_READOUT: rout_q <= rdata_q;
        default: ;
      endcase
      // return: SP takes BP before the first read
      if (cmd_i.act == ACT_EXEC && ir_q[15:14] == 2'd0 && ir_q[13:11] == 3'd2) begin
        rf_q[IDX_SP] <= rf_q[IDX_BP];
      end
    end
  end

  assign sts_o.group   = ir_q[15:14];
  assign sts_o.sub     = ir_q[13:11];
  assign sts_o.mod     = ir_q[12];
  assign sts_o.tt      = ir_q[11:10];
  assign sts_o.kind    = ir_q[13:12];
  assign sts_o.stopped = stop_q;
  assign read_word_o   = rout_q;
  assign regs_o        = rf_q;
  assign stopped_o     = stop_q;

endmodule

// ===== hdl/tcc16_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc16_ctrl
// Sequencer for mode handling, fetch and memory phases.
// ----------------------------------------------------------------------------
module tcc16_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [1:0]            mode_i,
  input  tcc16_pkg::tcc16_sts_t sts_i,
  output tcc16_pkg::tcc16_cmd_t cmd_o,
  output logic                  busy_o,
  output logic                  done_o,
  output logic                  refused_o
);
  import tcc16_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FETCH = 4'd1;
  localparam logic [3:0] S_IR    = 4'd2;
  localparam logic [3:0] S_EXEC  = 4'd3;
  localparam logic [3:0] S_MEM   = 4'd4;
  localparam logic [3:0] S_LOAD  = 4'd5;
  localparam logic [3:0] S_RET1  = 4'd6;
  localparam logic [3:0] S_RET2  = 4'd7;
  localparam logic [3:0] S_RET3  = 4'd8;
  localparam logic [3:0] S_CALL2 = 4'd9;
  localparam logic [3:0] S_RD    = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0] state_q, state_d;
  logic       ref_q, ref_d;
  logic       acc;

  assign acc    = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    ref_d   = ref_q;
    cmd_o   = '{act: ACT_NONE, asel: ASEL_IN};
    case (state_q)
      S_IDLE: if (acc) begin
        ref_d = 1'b0;
        case (mode_i)
          MODE_WRITE: begin
            cmd_o   = '{act: ACT_MEMWR_IN, asel: ASEL_IN};
            state_d = S_DONE;
          end
          MODE_RESTART: begin
            cmd_o   = '{act: ACT_RESTART, asel: ASEL_IN};
            state_d = S_DONE;
          end
          MODE_STEP: begin
            cmd_o   = '{act: ACT_STEP, asel: ASEL_IN};
            ref_d   = sts_i.stopped;
            state_d = sts_i.stopped ? S_DONE : S_FETCH;
          end
          default: begin
            cmd_o   = '{act: ACT_RDREQ, asel: ASEL_IN};
            state_d = S_RD;
          end
        endcase
      end
      S_FETCH: begin
        cmd_o   = '{act: ACT_NONE, asel: ASEL_PC};
        state_d = S_IR;
      end
      S_IR: begin
        cmd_o   = '{act: ACT_LATCH_IR, asel: ASEL_IN};
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_DONE;
        cmd_o   = '{act: ACT_EXEC, asel: ASEL_IN};
        if (sts_i.group == 2'd0 && sts_i.sub == 3'd2) begin
          state_d = S_RET1;
        end else if (sts_i.group == 2'd1 && !(sts_i.mod && sts_i.tt == 2'd3)
                     && !(!sts_i.mod && sts_i.tt == 2'd0)) begin
          state_d = S_MEM;
        end else if (sts_i.group == 2'd3 && sts_i.kind == 2'd3) begin
          cmd_o   = '{act: ACT_CALL1, asel: ASEL_SP};
          state_d = S_CALL2;
        end
      end
      S_MEM: begin
        if (!sts_i.mod) begin
          case (sts_i.tt)
            2'd1:    cmd_o = '{act: ACT_NONE, asel: ASEL_IMM};
            2'd2:    cmd_o = '{act: ACT_NONE, asel: ASEL_RB};
            default: cmd_o = '{act: ACT_NONE, asel: ASEL_OFF};
          endcase
          state_d = S_LOAD;
        end else begin
          case (sts_i.tt)
            2'd0:    cmd_o = '{act: ACT_STORE_RA, asel: ASEL_IMM};
            2'd1:    cmd_o = '{act: ACT_STORE_RA, asel: ASEL_RB};
            default: cmd_o = '{act: ACT_STORE_RA, asel: ASEL_OFF};
          endcase
          state_d = S_DONE;
        end
      end
      S_LOAD: begin
        cmd_o   = '{act: ACT_LOAD_RA, asel: ASEL_IN};
        state_d = S_DONE;
      end
      S_RET1: begin
        cmd_o   = '{act: ACT_NONE, asel: ASEL_SP};
        state_d = S_RET2;
      end
      S_RET2: begin
        cmd_o   = '{act: ACT_RET1, asel: ASEL_IN};
        state_d = S_RET3;
      end
      S_RET3: begin
        cmd_o   = '{act: ACT_NONE, asel: ASEL_SP};
        state_d = S_LOAD;
      end
      S_CALL2: begin
        cmd_o   = '{act: ACT_CALL2, asel: ASEL_SP};
        state_d = S_DONE;
      end
      S_RD: begin
        cmd_o   = '{act: ACT_READOUT, asel: ASEL_IN};
        state_d = S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    // return tail reuses S_LOAD but writes PC
    if (state_q == S_LOAD && sts_i.group == 2'd0) begin
      cmd_o = '{act: ACT_RET2, asel: ASEL_IN};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ref_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ref_q   <= ref_d;
    end
  end

  assign done_o    = (state_q == S_DONE);
  assign refused_o = ref_q;

endmodule

// ===== hdl/teaching_cpu_core_16bit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teaching_cpu_core_16bit
// 16-bit teaching core with internal word memory and command interface.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its result
// appears for one cycle with done_o and cannot be stalled. Memory write,
// restart and a refused step go straight to the done state, and memory
// read passes through a readout state. An executed step runs fetch, IR
// latch and execute, then one single-port memory access per cycle for
// loads, stores, call and return. The user must write start registers
// through the cfg port only while idle; the block does not enforce this.
module teaching_cpu_core_16bit #(
  parameter int unsigned MemWords = tcc16_pkg::DefMemWords
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [15:0] mem_address_i,
  input  logic [15:0] write_word_i,
  output logic        done_o,
  output logic        status_o,
  output logic [15:0] read_word_o,
  output logic [15:0] gpr0_o,
  output logic [15:0] gpr1_o,
  output logic [15:0] gpr2_o,
  output logic [15:0] gpr3_o,
  output logic [15:0] accumulator_o,
  output logic [15:0] stack_pointer_o,
  output logic [15:0] base_pointer_o,
  output logic [15:0] program_counter_o,
  output logic        stopped_flag_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import tcc16_pkg::*;

  tcc16_cmd_t  cmd;
  tcc16_sts_t  sts;
  logic [15:0] regs [8];
  logic [15:0] spc_q, ssp_q, sbp_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spc_q <= '0;
      ssp_q <= '0;
      sbp_q <= '0;
    end else if (cfg_valid) begin
      case (cfg_index_i)
        CFG_START_PC: spc_q <= cfg_data_i;
        CFG_START_SP: ssp_q <= cfg_data_i;
        CFG_START_BP: sbp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tcc16_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .mode_i, .sts_i(sts), .cmd_o(cmd),
    .busy_o(busy), .done_o(done_o), .refused_o(status_o)
  );

  tcc16_datapath #(.MemWords(MemWords)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .in_addr_i(mem_address_i),
    .in_wdata_i(write_word_i), .start_pc_i(spc_q), .start_sp_i(ssp_q),
    .start_bp_i(sbp_q), .read_word_o, .regs_o(regs), .stopped_o(stopped_flag_o)
  );

  assign gpr0_o            = regs[0];
  assign gpr1_o            = regs[1];
  assign gpr2_o            = regs[2];
  assign gpr3_o            = regs[3];
  assign accumulator_o     = regs[4];
  assign stack_pointer_o   = regs[5];
  assign base_pointer_o    = regs[6];
  assign program_counter_o = regs[7];

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> busy)
    else $error("done without busy");
  a_refuse_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> stopped_flag_o)
    else $error("refusal while running");
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("command not taken");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 16-bit teaching core: directed instructions,
// then randomized programs and memory traffic, checked against a predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import tcc16_pkg::*;

  localparam logic [1:0] GRP_CTRL = 2'd0;
  localparam logic [1:0] GRP_MEM  = 2'd1;
  localparam logic [1:0] GRP_ALU  = 2'd2;
  localparam logic [1:0] GRP_JMP  = 2'd3;

  localparam logic [2:0] CTL_HALT = 3'd0;
  localparam logic [2:0] CTL_NOP  = 3'd1;
  localparam logic [2:0] CTL_RET  = 3'd2;

  localparam logic       MEM_LOAD  = 1'b0;
  localparam logic       MEM_STORE = 1'b1;
  localparam logic [1:0] AM_IMM = 2'd0;
  localparam logic [1:0] AM_DIR = 2'd1;
  localparam logic [1:0] AM_IND = 2'd2;
  localparam logic [1:0] AM_OFF = 2'd3;
  localparam logic [1:0] ST_DIR = 2'd0;
  localparam logic [1:0] ST_IND = 2'd1;
  localparam logic [1:0] ST_OFF = 2'd2;

  localparam logic [2:0] ALU_NEG  = 3'd0;
  localparam logic [2:0] ALU_ADD  = 3'd1;
  localparam logic [2:0] ALU_ADDI = 3'd2;
  localparam logic [2:0] ALU_SUB  = 3'd3;
  localparam logic [2:0] ALU_SUBI = 3'd4;
  localparam logic [2:0] ALU_MOV  = 3'd7;

  localparam logic [1:0] JK_JMP  = 2'd0;
  localparam logic [1:0] JK_JZ   = 2'd1;
  localparam logic [1:0] JK_JN   = 2'd2;
  localparam logic [1:0] JK_CALL = 2'd3;

  typedef struct packed {
    logic             status;
    logic [15:0]      rd;
    logic [7:0][15:0] regs;
    logic             halted;
  } core_view_t;

  class core_scoreboard;
    logic [15:0] start_pc, start_sp, start_bp;
    logic [15:0] r [8];
    logic        halted;
    logic [15:0] mem [DefMemWords];
    bit          seen [DefMemWords];
    int          seen_list [$];
    core_view_t  pending_q [$];
    int          errors, checked;

    function new();
      for (int i = 0; i < 8; i++) r[i] = '0;
      halted = 0; start_pc = '0; start_sp = '0; start_bp = '0;
      errors = 0; checked = 0;
    endfunction

    task report_mismatch(string what, logic [15:0] got, logic [15:0] exp);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp, $realtime);
      errors++;
    endtask

    function logic [15:0] mrd(logic [15:0] a);
      return mem[a[15:1]];
    endfunction

    function void mwr(logic [15:0] a, logic [15:0] v);
      mem[a[15:1]] = v;
      if (!seen[a[15:1]]) begin
        seen[a[15:1]] = 1;
        seen_list.push_back(int'(a[15:1]));
      end
    endfunction

    function logic [15:0] off_addr(logic [15:0] base, logic [15:0] ins);
      return base + ({{11{ins[4]}}, ins[4:0]} << 1);
    endfunction

    function void set_start(logic [1:0] idx, logic [15:0] v);
      case (idx)
        CFG_START_PC: start_pc = v;
        CFG_START_SP: start_sp = v;
        CFG_START_BP: start_bp = v;
        default: ;
      endcase
    endfunction

    // first unwritten word the next step would read, if any
    function bit missing_read(output logic [15:0] a, output bit is_fetch);
      logic [15:0] ins, pc1;
      logic [2:0]  rb;
      is_fetch = 0; a = '0;
      if (halted) return 0;
      if (!seen[r[IDX_PC][15:1]]) begin
        a = r[IDX_PC]; is_fetch = 1; return 1;
      end
      ins = mrd(r[IDX_PC]);
      pc1 = r[IDX_PC] + 16'd2;
      rb = ins[7:5];
      if (ins[15:14] == GRP_CTRL && ins[13:11] == CTL_RET) begin
        a = r[IDX_BP];
        if (!seen[a[15:1]]) return 1;
        a = r[IDX_BP] - 16'd2;
        return !seen[a[15:1]];
      end
      if (ins[15:14] == GRP_MEM && ins[12] == MEM_LOAD && ins[11:10] != AM_IMM) begin
        case (ins[11:10])
          AM_DIR: a = {8'd0, ins[7:0]};
          AM_IND: a = (rb == IDX_PC) ? pc1 : r[rb];
          default: a = off_addr((rb == IDX_PC) ? pc1 : r[rb], ins);
        endcase
        return !seen[a[15:1]];
      end
      return 0;
    endfunction

    function void exec_ins(logic [15:0] ins);
      logic [2:0]  ra, rb;
      logic [7:0]  imm;
      ra = ins[10:8]; rb = ins[7:5]; imm = ins[7:0];
      case (ins[15:14])
        GRP_CTRL: begin
          if (ins[13:11] == CTL_HALT) halted = 1;
          else if (ins[13:11] == CTL_RET) begin
            r[IDX_SP] = r[IDX_BP];
            r[IDX_BP] = mrd(r[IDX_SP]);
            r[IDX_SP] = r[IDX_SP] - 16'd2;
            r[IDX_PC] = mrd(r[IDX_SP]);
          end
        end
        GRP_MEM: begin
          if (ins[12] == MEM_LOAD) begin
            case (ins[11:10])
              AM_IMM: r[ra] = {8'd0, imm};
              AM_DIR: r[ra] = mrd({8'd0, imm});
              AM_IND: r[ra] = mrd(r[rb]);
              default: r[ra] = mrd(off_addr(r[rb], ins));
            endcase
          end else begin
            case (ins[11:10])
              ST_DIR: mwr({8'd0, imm}, r[ra]);
              ST_IND: mwr(r[rb], r[ra]);
              ST_OFF: mwr(off_addr(r[rb], ins), r[ra]);
              default: ;
            endcase
          end
        end
        GRP_ALU: begin
          case (ins[13:11])
            ALU_NEG:  r[IDX_AC] = 16'd0 - r[ra];
            ALU_ADD:  r[IDX_AC] = r[ra] + r[rb];
            ALU_ADDI: r[IDX_AC] = r[ra] + {8'd0, imm};
            ALU_SUB:  r[IDX_AC] = r[ra] - r[rb];
            ALU_SUBI: r[IDX_AC] = r[ra] - {8'd0, imm};
            ALU_MOV:  r[ra] = r[rb];
            default: ;
          endcase
        end
        default: begin
          case (ins[13:12])
            JK_JMP: r[IDX_PC] = {4'd0, ins[11:0]};
            JK_JZ: if (r[IDX_AC] == 16'd0) r[IDX_PC] = {4'd0, ins[11:0]};
            JK_JN: if (r[IDX_AC][15]) r[IDX_PC] = {4'd0, ins[11:0]};
            default: begin
              mwr(r[IDX_SP], r[IDX_PC]);
              r[IDX_SP] = r[IDX_SP] + 16'd2;
              r[IDX_PC] = {4'd0, ins[11:0]};
              mwr(r[IDX_SP], r[IDX_BP]);
              r[IDX_BP] = r[IDX_SP];
              r[IDX_SP] = r[IDX_SP] + 16'd2;
            end
          endcase
        end
      endcase
    endfunction

    function void note(logic [1:0] mode, logic [15:0] addr, logic [15:0] wdata);
      core_view_t e;
      logic [15:0] ins;
      e = '0;
      case (mode)
        MODE_WRITE: mwr(addr, wdata);
        MODE_RESTART: begin
          for (int i = 0; i < 8; i++) r[i] = '0;
          r[IDX_PC] = start_pc; r[IDX_SP] = start_sp; r[IDX_BP] = start_bp;
          halted = 0;
        end
        MODE_STEP: begin
          if (halted) e.status = 1;
          else begin
            ins = mrd(r[IDX_PC]);
            r[IDX_PC] = r[IDX_PC] + 16'd2;
            exec_ins(ins);
          end
        end
        default: e.rd = mrd(addr);
      endcase
      for (int i = 0; i < 8; i++) e.regs[i] = r[i];
      e.halted = halted;
      pending_q.push_back(e);
    endfunction

    task check(core_view_t got);
      core_view_t e;
      if (pending_q.size() == 0) begin
        report_mismatch("result with no pending transaction", 16'd0, 16'd0);
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (got.status !== e.status) report_mismatch("status", 16'(got.status), 16'(e.status));
      if (got.rd !== e.rd) report_mismatch("read_word", got.rd, e.rd);
      for (int i = 0; i < 8; i++)
        if (got.regs[i] !== e.regs[i]) report_mismatch($sformatf("reg%0d", i), got.regs[i], e.regs[i]);
      if (got.halted !== e.halted) report_mismatch("stopped_flag", 16'(got.halted), 16'(e.halted));
    endtask
  endclass

  logic        clk_i, rst_ni;
  logic        start, busy, done_o;
  logic [1:0]  mode_i;
  logic [15:0] mem_address_i, write_word_i;
  logic        status_o, stopped_flag_o;
  logic [15:0] read_word_o, gpr0_o, gpr1_o, gpr2_o, gpr3_o;
  logic [15:0] accumulator_o, stack_pointer_o, base_pointer_o, program_counter_o;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  core_scoreboard sb;
  int idle_pct;
  int n_sent;

  teaching_cpu_core_16bit u_dut (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .mem_address_i, .write_word_i,
    .done_o, .status_o, .read_word_o, .gpr0_o, .gpr1_o, .gpr2_o, .gpr3_o,
    .accumulator_o, .stack_pointer_o, .base_pointer_o, .program_counter_o,
    .stopped_flag_o, .cfg_valid, .cfg_ready, .cfg_index_i, .cfg_data_i
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 600000);
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check('{status_o, read_word_o,
                 {program_counter_o, base_pointer_o, stack_pointer_o, accumulator_o,
                  gpr3_o, gpr2_o, gpr1_o, gpr0_o},
                 stopped_flag_o});
    end
  end

  function automatic logic [15:0] enc_mem(logic md, logic [1:0] tt, logic [1:0] ra2,
                                          logic [7:0] lo);
    return {GRP_MEM, 1'b0, md, tt, ra2, lo};
  endfunction

  function automatic logic [15:0] enc_alu(logic [2:0] sub, logic [2:0] ra, logic [7:0] lo);
    return {GRP_ALU, sub, ra, lo};
  endfunction

  function automatic logic [15:0] enc_jmp(logic [1:0] kind, logic [11:0] tgt);
    return {GRP_JMP, kind, tgt};
  endfunction

  function automatic logic [15:0] enc_ctl(logic [2:0] op);
    return {GRP_CTRL, op, 11'd0};
  endfunction

  function automatic logic [15:0] rand_instr();
    logic [15:0] w;
    w = 16'($urandom);
    if (w[15:14] == GRP_CTRL) begin
      // keep halts rare so programs run for a while
      if ($urandom_range(15) == 0) w[13:11] = CTL_HALT;
      else if ($urandom_range(2) == 0) w[13:11] = CTL_RET;
      else if (w[13:11] == CTL_HALT) w[13:11] = CTL_NOP;
    end
    return w;
  endfunction

  task automatic send(logic [1:0] mode, logic [15:0] addr, logic [15:0] wdata);
    start <= 1'b1;
    mode_i <= mode;
    mem_address_i <= addr;
    write_word_i <= wdata;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note(mode, addr, wdata);
    n_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic fill_and_step();
    logic [15:0] a;
    bit          fetch;
    while (sb.missing_read(a, fetch))
      send(MODE_WRITE, a, fetch ? rand_instr() : 16'($urandom));
    send(MODE_STEP, 16'($urandom), 16'($urandom));
  endtask

  task automatic run_instr(logic [15:0] ins);
    send(MODE_WRITE, sb.r[IDX_PC], ins);
    fill_and_step();
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic load_start(logic [15:0] pc, logic [15:0] sp, logic [15:0] bp);
    logic [15:0] vals [3];
    vals = '{pc, sp, bp};
    for (int i = 0; i < 3; i++) begin
      cfg_valid   <= 1'b1;
      cfg_index_i <= 2'(i);
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready) @(posedge clk_i);
      sb.set_start(2'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(int n);
    int stop_at, pick, idx;
    stop_at = n_sent + n;
    while (n_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 6 || (sb.halted && pick < 60)) begin
        send(MODE_RESTART, 16'($urandom), 16'($urandom));
      end else if (pick < 14) begin
        send(MODE_WRITE, 16'($urandom), 16'($urandom));
      end else if (pick < 22 && sb.seen_list.size() != 0) begin
        idx = sb.seen_list[$urandom_range(sb.seen_list.size() - 1)];
        send(MODE_READ, {idx[14:0], 1'($urandom)}, 16'($urandom));
      end else begin
        fill_and_step();
      end
    end
    drain();
  endtask

  initial begin
    sb = new();
    n_sent = 0;
    idle_pct = 18;
    rst_ni = 1'b0;
    start = 1'b0;
    mode_i = MODE_WRITE;
    mem_address_i = '0;
    write_word_i = '0;
    cfg_valid = 1'b0;
    cfg_index_i = CFG_START_PC;
    cfg_data_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    load_start(16'h0010, 16'h0400, 16'h0400);
    send(MODE_WRITE, 16'hFFFF, 16'hFFFF);
    send(MODE_READ, 16'hFFFE, 16'h0000);
    send(MODE_RESTART, 16'h0000, 16'h0000);
    run_instr(enc_mem(MEM_LOAD, AM_IMM, 2'd0, 8'hFF));
    run_instr(enc_mem(MEM_LOAD, AM_IMM, 2'd1, 8'h01));
    run_instr(enc_alu(ALU_SUB, 3'd1, {3'd0, 5'd0}));
    run_instr(enc_jmp(JK_JN, 12'hFFF));
    run_instr(enc_alu(ALU_ADDI, 3'd0, 8'hFF));
    run_instr(enc_alu(ALU_NEG, 3'd0, 8'h00));
    run_instr(enc_alu(ALU_ADD, 3'd4, {3'd0, 5'd0}));
    run_instr(enc_alu(ALU_SUBI, 3'd1, 8'h01));
    run_instr(enc_jmp(JK_JZ, 12'h100));
    run_instr(enc_alu(ALU_MOV, 3'd2, {3'd0, 5'd0}));
    run_instr(enc_mem(MEM_STORE, ST_OFF, 2'd0, {IDX_SP, 5'h10}));
    run_instr(enc_mem(MEM_LOAD, AM_OFF, 2'd0, {IDX_SP, 5'h10}));
    run_instr(enc_jmp(JK_CALL, 12'h200));
    run_instr(enc_ctl(CTL_RET));
    run_instr(enc_ctl(CTL_NOP));
    run_instr(enc_ctl(CTL_HALT));
    send(MODE_STEP, 16'h0000, 16'h0000);
    send(MODE_RESTART, 16'h0000, 16'h0000);
    drain();

    load_start(16'h0000, 16'h0000, 16'h0000);
    send(MODE_RESTART, 16'h0000, 16'h0000);
    random_phase(380);

    idle_pct = 49;
    load_start(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(MODE_RESTART, 16'h0000, 16'h0000);
    random_phase(380);

    idle_pct = 0;
    load_start(16'($urandom_range(16'h0FFF)), 16'($urandom), 16'($urandom));
    send(MODE_RESTART, 16'h0000, 16'h0000);
    random_phase(380);

    $display("Run covered %0d transactions with %0d results checked", n_sent, sb.checked);
    $display("Distinct memory words written: %0d, mismatches: %0d",
             sb.seen_list.size(), sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
